// File: hdl/dnle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_pkg
// Types and constants shared by the DNS name label encoder modules.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned CountW  = 6;
  localparam int unsigned SeenW   = 9;

  localparam logic [CharW-1:0] DotChar = 8'd46;
  localparam logic [CharW-1:0] NulChar = 8'd0;

  typedef struct packed {
    logic [CharW-1:0] host_char;
    logic             end_of_name;
  } dnle_in_t;

  typedef struct packed {
    logic [CharW-1:0] wire_byte;
    logic             name_done;
    logic             label_truncated;
  } dnle_out_t;

  typedef struct packed {
    logic              shift;
    logic              wr;
    logic [CountW-1:0] wr_idx;
    logic [CharW-1:0]  wr_byte;
  } dnle_cell_ctl_t;

  typedef enum logic [1:0] {
    StIdle,
    StLen,
    StBytes,
    StTerm
  } dnle_state_e;

endpackage
`default_nettype wire

// File: hdl/dns_name_label_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core
// Encodes a dotted host name, one character per beat, into DNS wire form.
// ----------------------------------------------------------------------------
// Label characters are written into a chain of LabelMax byte cells, one cell
// per character; the input is ready whenever the encoder is not draining.
// A dot or zero character within the name limit, or end_of_name, drains a
// non-empty held label: the length byte, then the label bytes shifted out of
// the head cell, all through a single output register, then the zero
// terminator at end_of_name. Output stalls hold the drain in place.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_core #(
  parameter int unsigned LabelMax = 62,
  parameter int unsigned NameMax  = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dnle_pkg::dnle_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dnle_pkg::dnle_out_t      out_data_o
);
  import dnle_pkg::*;

  dnle_state_e       state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [SeenW-1:0]  seen_q, seen_d;
  logic              ovf_q, ovf_d;
  logic              term_q, term_d;
  logic              out_valid_q, out_valid_d;
  dnle_out_t         out_q, out_d;

  dnle_cell_ctl_t    ctl;
  logic [CharW-1:0]  chain [LabelMax];

  logic in_fire, can_load, is_sep, in_name, store;
  logic [CountW-1:0] count_st;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire  = in_valid_i && in_ready_o;
  assign can_load = !out_valid_q || out_ready_i;
  assign is_sep   = (in_data_i.host_char == DotChar) || (in_data_i.host_char == NulChar);
  assign in_name  = seen_q < SeenW'(NameMax);
  assign store    = in_fire && in_name && !is_sep && (count_q < CountW'(LabelMax));
  assign count_st = store ? count_q + CountW'(1) : count_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (((in_name && is_sep) || in_data_i.end_of_name) && (count_st != '0)) begin
            state_d = StLen;
          end else if (in_data_i.end_of_name) begin
            state_d = StTerm;
          end
        end
      end
      StLen: begin
        if (can_load) state_d = StBytes;
      end
      StBytes: begin
        if (can_load && (count_q == CountW'(1))) state_d = term_q ? StTerm : StIdle;
      end
      StTerm: begin
        if (can_load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    seen_d      = seen_q;
    ovf_d       = ovf_q;
    term_d      = term_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ctl.shift   = 1'b0;
    ctl.wr      = store;
    ctl.wr_idx  = count_q;
    ctl.wr_byte = in_data_i.host_char;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          count_d = count_st;
          term_d  = in_data_i.end_of_name;
          if (in_name) begin
            seen_d = seen_q + SeenW'(1);
            if (in_data_i.host_char == NulChar) seen_d = SeenW'(NameMax);
            if (!is_sep && (count_q >= CountW'(LabelMax))) ovf_d = 1'b1;
          end
          if (in_data_i.end_of_name) seen_d = '0;
        end
      end
      StLen: begin
        if (can_load) begin
          out_valid_d               = 1'b1;
          out_d.wire_byte           = CharW'(count_q);
          out_d.name_done           = 1'b0;
          out_d.label_truncated     = ovf_q;
          ovf_d                     = 1'b0;
        end
      end
      StBytes: begin
        if (can_load) begin
          out_valid_d           = 1'b1;
          out_d.wire_byte       = chain[0];
          out_d.name_done       = 1'b0;
          out_d.label_truncated = 1'b0;
          ctl.shift             = 1'b1;
          count_d               = count_q - CountW'(1);
        end
      end
      StTerm: begin
        if (can_load) begin
          out_valid_d           = 1'b1;
          out_d.wire_byte       = NulChar;
          out_d.name_done       = 1'b1;
          out_d.label_truncated = 1'b0;
          term_d                = 1'b0;
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < LabelMax; g++) begin : g_cell
    dnle_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .nxt_i ((g == LabelMax - 1) ? NulChar : chain[(g + 1) % LabelMax]),
      .byte_o(chain[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      seen_q      <= '0;
      ovf_q       <= 1'b0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      seen_q      <= seen_d;
      ovf_q       <= ovf_d;
      term_q      <= term_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: hdl/dnle_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_cell
// One byte slot of the label chain: loads a character when addressed and
// passes its byte toward the head of the chain on each drain step.
// ----------------------------------------------------------------------------
module dnle_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic                    clk_i,
  input  wire dnle_pkg::dnle_cell_ctl_t ctl_i,
  input  wire logic [dnle_pkg::CharW-1:0] nxt_i,
  output logic      [dnle_pkg::CharW-1:0] byte_o
);
  import dnle_pkg::*;

  logic [CharW-1:0] byte_q;
  logic [CharW-1:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.shift) begin
      byte_d = nxt_i;
    end else if (ctl_i.wr && (ctl_i.wr_idx == CountW'(Idx))) begin
      byte_d = ctl_i.wr_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule
`default_nettype wire

// File: hdl/dnle_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_checker
// Port-level checks for the DNS name label encoder, bound to the top level.
// ----------------------------------------------------------------------------
module dnle_checker #(
  parameter int unsigned LabelMax = 62
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire dnle_pkg::dnle_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire dnle_pkg::dnle_out_t out_data_o
);
  import dnle_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.name_done |->
      out_data_o.wire_byte == NulChar && !out_data_o.label_truncated)
    else $error("terminator beat malformed");

  a_trunc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.label_truncated |->
      out_data_o.wire_byte == CharW'(LabelMax))
    else $error("truncated label length mismatch");

  a_no_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.name_done && out_data_o.label_truncated |->
      out_data_o.wire_byte != NulChar)
    else $error("length byte of zero emitted");

  a_end_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.end_of_name |=> !in_ready_o)
    else $error("input taken before terminator sent");

endmodule

bind dns_name_label_encoder_core dnle_checker #(
  .LabelMax(LabelMax)
) u_dnle_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
`default_nettype wire

// File: tb/tb_dns_name_label_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_name_label_encoder_core
// Self-checking bench for the DNS name label encoder core.
// ----------------------------------------------------------------------------
// Host names go in one character per beat, with random gaps on the input and
// random stalls on the output. An in-bench encoder predicts the wire bytes
// (length bytes, label bytes, zero terminator) for every accepted character,
// and every output beat is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb_dns_name_label_encoder_core;
  import dnle_pkg::*;

  localparam int LabelMax = 62;
  localparam int NameMax  = 256;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  dnle_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  dnle_out_t out_data_o;

  dns_name_label_encoder_core #(
    .LabelMax(LabelMax),
    .NameMax (NameMax)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // encoder prediction state
  logic [7:0] held_bytes [LabelMax];
  int         held_len;
  int         name_pos;
  logic       held_cut;
  dnle_out_t  wire_q [$];

  int   err_count;
  int   chars_sent;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;

  function automatic void push_wire(input logic [7:0] b, input logic done,
                                    input logic cut);
    dnle_out_t w;
    w.wire_byte       = b;
    w.name_done       = done;
    w.label_truncated = cut;
    wire_q.push_back(w);
  endfunction

  function automatic void emit_held_label();
    if (held_len > 0) begin
      push_wire(8'(held_len), 1'b0, held_cut);
      for (int k = 0; k < held_len; k++) push_wire(held_bytes[k], 1'b0, 1'b0);
    end
    held_len = 0;
    held_cut = 1'b0;
  endfunction

  function automatic void encode_char(input logic [7:0] c, input logic eon);
    if (name_pos < NameMax) begin
      name_pos++;
      if (c == DotChar || c == NulChar) begin
        emit_held_label();
        if (c == NulChar) name_pos = NameMax;
      end else if (held_len < LabelMax) begin
        held_bytes[held_len] = c;
        held_len++;
      end else begin
        held_cut = 1'b1;
      end
    end
    if (eon) begin
      emit_held_label();
      push_wire(NulChar, 1'b1, 1'b0);
      name_pos = 0;
    end
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'($urandom_range(97, 122));
  endfunction

  // any character but the dot and zero
  function automatic logic [7:0] pick_label_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return pick_letter();
    c = 8'($urandom_range(1, 255));
    if (c == DotChar) c = 8'hAE;
    return c;
  endfunction

  function automatic logic [7:0] pick_noise_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return pick_letter();
    if (r < 80) return DotChar;
    if (r < 96) return 8'($urandom_range(1, 255));
    return NulChar;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eon);
    int   gap;
    logic took;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    encode_char(c, eon);
    in_valid_i <= 1'b1;
    in_data_i  <= '{host_char: c, end_of_name: eon};
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic end_it);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], end_it && (i == s.len() - 1));
  endtask

  task automatic send_label(input int n, input logic end_it);
    for (int i = 0; i < n; i++) send_char(pick_label_char(), end_it && (i == n - 1));
  endtask

  // output side
  initial begin
    int   stall;
    logic took;
    out_ready_i <= 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        took = out_valid_o;
        @(posedge clk_i);
      end while (!took);
    end
  end

  // beat checker; inputs only move at rising edges, so the falling edge
  // sees what the next rising edge accepts
  always @(negedge clk_i) begin
    dnle_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (wire_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat byte=%02h done=%0b trunc=%0b", $time,
                 out_data_o.wire_byte, out_data_o.name_done,
                 out_data_o.label_truncated);
      end else begin
        want = wire_q.pop_front();
        if (out_data_o.wire_byte !== want.wire_byte ||
            out_data_o.name_done !== want.name_done ||
            out_data_o.label_truncated !== want.label_truncated) begin
          err_count++;
          $display("%0t: mismatch exp byte=%02h done=%0b trunc=%0b got byte=%02h done=%0b trunc=%0b",
                   $time, want.wire_byte, want.name_done, want.label_truncated,
                   out_data_o.wire_byte, out_data_o.name_done,
                   out_data_o.label_truncated);
        end
      end
    end
  end

  task automatic test_basic_names();
    send_text("ab.c", 1'b1);
    send_text("q", 1'b1);
    send_text(".", 1'b1);
  endtask

  task automatic test_empty_labels();
    send_text("..x..yz.", 1'b1);
  endtask

  task automatic test_char_extremes();
    send_char(8'hFF, 1'b0);
    send_char(8'h01, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(DotChar, 1'b0);
    send_char(8'h80, 1'b1);
  endtask

  task automatic test_zero_char();
    send_text("ab", 1'b0);
    send_char(NulChar, 1'b0);
    send_text("c.d", 1'b1);
    send_char(NulChar, 1'b1);
  endtask

  task automatic test_long_labels();
    send_label(LabelMax, 1'b0);
    send_char(DotChar, 1'b0);
    send_label(LabelMax + 1, 1'b1);
    send_label(70, 1'b0);
    send_char(DotChar, 1'b0);
    send_text("ok", 1'b1);
    send_label(LabelMax, 1'b1);
  endtask

  task automatic test_name_limit();
    // 300 characters: the tail past the limit is dropped, dots included
    for (int i = 0; i < 300; i++)
      send_char((i % 20 == 19) ? DotChar : pick_letter(), i == 299);
    // exactly at the limit, then end_of_name on an ignored character
    for (int i = 0; i < NameMax; i++)
      send_char((i % 30 == 29) ? DotChar : pick_letter(), 1'b0);
    send_char(pick_letter(), 1'b1);
  endtask

  task automatic test_random_names();
    int first;
    int nlab;
    int len;
    first = chars_sent;
    while (chars_sent - first < 150) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) send_char(pick_noise_char(), i == len - 1);
      end else begin
        nlab = $urandom_range(1, 4);
        for (int l = 0; l < nlab; l++) begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(55, 66)
                                             : $urandom_range(1, 8);
          send_label(len, (l == nlab - 1) && $urandom_range(0, 3) != 0);
          if (l != nlab - 1) send_char(DotChar, 1'b0);
          else if (!in_data_i.end_of_name) send_char(DotChar, 1'b1);
        end
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    held_len   = 0;
    name_pos   = 0;
    held_cut   = 1'b0;
    err_count  = 0;
    chars_sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_names();
    test_empty_labels();
    test_char_extremes();
    test_zero_char();
    test_long_labels();
    test_name_limit();
    test_random_names();

    in_valid_i <= 1'b0;
    while (wire_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/dnle_pkg.sv
hdl/dnle_cell.sv
hdl/dns_name_label_encoder_core.sv
hdl/dnle_checker.sv
tb/tb_dns_name_label_encoder_core.sv
